FILE: rtl/sset_pkg.sv
// ----------------------------------------------------------------------------
// sset_pkg
// Shared types and constants for the sorted unique id set: request and
// status codes, sequencer states and result field widths.
// ----------------------------------------------------------------------------
package sset_pkg;

  // default sizing of the set
  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  // fixed result field widths
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned COUNT_W  = 7;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_ABSENT  = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SCAN = 1'b1
  } fsm_t;

endpackage

FILE: rtl/sset_if.sv
// ----------------------------------------------------------------------------
// sset_req_if / sset_rsp_if
// Valid/ready channels for requests into the set and results out of it.
// ----------------------------------------------------------------------------
interface sset_req_if #(
  parameter int unsigned KEY_WIDTH = sset_pkg::KEY_WIDTH_DEF
);
  logic                                valid;
  logic                                ready;
  logic        [sset_pkg::REQ_W-1:0]   req_type;
  logic signed [KEY_WIDTH-1:0]         key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface sset_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [sset_pkg::STATUS_W-1:0]       status;
  logic                                found;
  logic [sset_pkg::POS_W-1:0]          position;
  logic [sset_pkg::COUNT_W-1:0]        count;

  modport source (output valid, output status, output found, output position,
                  output count, input ready);
  modport sink   (input valid, input status, input found, input position,
                  input count, output ready);
endinterface

FILE: rtl/sset_ram.sv
// ----------------------------------------------------------------------------
// sset_ram
// Simple dual-port key store: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module sset_ram #(
  parameter int unsigned DEPTH = sset_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = sset_pkg::KEY_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic signed [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]           rd_addr,
  output logic signed [WIDTH-1:0] rd_data
);

  logic signed [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/sorted_unique_id_set.sv
// ----------------------------------------------------------------------------
// sorted_unique_id_set
// Sorted set of distinct signed keys held in one memory. Each request walks
// the stored keys in ascending order, one per cycle unless its final step
// stalls, inserting, deleting or looking up a key; clear empties the set.
//
//   channel  | dir | payload                          | transfer
//   ---------+-----+----------------------------------+------------------
//   in_req   | in  | req_type, key                    | valid && ready
//   out_rsp  | out | status, found, position, count   | valid && ready
//
// A request is accepted while idle, then takes one step per stored key
// visited. Lookup, a missed delete, an insert of a held key and an insert
// into a full set stop at the first key not below the request key; a new
// insert and a hit delete walk to the end (count + 1 steps); clear takes
// one step. Reset clears the count and the sequencer, not the key store.
// A waiting result stalls only the final step of the next request.
// ----------------------------------------------------------------------------
module sorted_unique_id_set #(
  parameter int unsigned CAPACITY  = sset_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = sset_pkg::KEY_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sset_req_if.sink     in_req,
  sset_rsp_if.source   out_rsp
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // sequencer state
  sset_pkg::fsm_t          state_r, state_nxt;
  sset_pkg::req_type_t     op_r, op_nxt;
  logic signed [KEY_WIDTH-1:0] key_r, key_nxt;
  logic signed [KEY_WIDTH-1:0] carry_r, carry_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic                    placed_r, placed_nxt;

  // memory ports
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic signed [KEY_WIDTH-1:0] wr_data;
  logic [AW-1:0]               rd_addr;
  logic signed [KEY_WIDTH-1:0] rd_data;

  // per-step decision
  logic                        s_we, s_adv, s_done, s_placed;
  logic [AW-1:0]               s_wa, s_pos;
  logic signed [KEY_WIDTH-1:0] s_wd, s_carry;
  logic [CW-1:0]               s_cnt;
  sset_pkg::status_t           res_status;
  logic                        res_found;
  logic [AW-1:0]               res_pos;

  // output register
  logic                          out_vld_r;
  sset_pkg::status_t             out_status_r;
  logic                          out_found_r;
  logic [sset_pkg::POS_W-1:0]    out_pos_r;
  logic [sset_pkg::COUNT_W-1:0]  out_cnt_r;

  logic          at_end, full, key_eq, key_gt, finish_go, commit, in_xfer;
  logic [CW-1:0] idx_inc, idx_dec;
  logic [63:0]   pos_ext, cnt_ext;

  sset_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // compare the key read back against the request key
  assign at_end    = (idx_r == cnt_r);
  assign full      = (cnt_r == CW'(CAPACITY));
  assign key_eq    = (rd_data == key_r);
  assign key_gt    = (rd_data > key_r);
  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);
  assign finish_go = !out_vld_r || out_rsp.ready;
  assign in_xfer   = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == sset_pkg::FSM_IDLE);

  // one step of the walk over the stored keys
  always_comb begin
    s_we       = 1'b0;
    s_wa       = idx_r[AW-1:0];
    s_wd       = key_r;
    s_adv      = 1'b0;
    s_done     = 1'b0;
    s_placed   = placed_r;
    s_carry    = carry_r;
    s_pos      = pos_r;
    s_cnt      = cnt_r;
    res_status = sset_pkg::STAT_DONE;
    res_found  = 1'b0;
    res_pos    = '0;
    case (op_r)
      sset_pkg::REQ_INSERT: begin
        if (!placed_r) begin
          if (at_end) begin
            s_done = 1'b1;
            if (full) begin
              res_status = sset_pkg::STAT_FULL;
            end else begin
              // key goes after every stored key
              s_we    = 1'b1;
              s_cnt   = cnt_r + CW'(1);
              res_pos = idx_r[AW-1:0];
            end
          end else if (key_eq) begin
            s_done     = 1'b1;
            res_status = sset_pkg::STAT_PRESENT;
            res_found  = 1'b1;
            res_pos    = idx_r[AW-1:0];
          end else if (key_gt) begin
            if (full) begin
              s_done     = 1'b1;
              res_status = sset_pkg::STAT_FULL;
            end else begin
              // drop the key here and carry the displaced one upward
              s_we     = 1'b1;
              s_carry  = rd_data;
              s_placed = 1'b1;
              s_pos    = idx_r[AW-1:0];
              s_adv    = 1'b1;
            end
          end else begin
            s_adv = 1'b1;
          end
        end else begin
          s_we = 1'b1;
          s_wd = carry_r;
          if (at_end) begin
            s_done  = 1'b1;
            s_cnt   = cnt_r + CW'(1);
            res_pos = pos_r;
          end else begin
            s_carry = rd_data;
            s_adv   = 1'b1;
          end
        end
      end
      sset_pkg::REQ_DELETE: begin
        if (!placed_r) begin
          if (at_end || key_gt) begin
            s_done     = 1'b1;
            res_status = sset_pkg::STAT_ABSENT;
          end else if (key_eq) begin
            s_placed = 1'b1;
            s_pos    = idx_r[AW-1:0];
            s_adv    = 1'b1;
          end else begin
            s_adv = 1'b1;
          end
        end else if (at_end) begin
          s_done    = 1'b1;
          s_cnt     = cnt_r - CW'(1);
          res_found = 1'b1;
          res_pos   = pos_r;
        end else begin
          // close the gap: move this key down by one
          s_we  = 1'b1;
          s_wa  = idx_dec[AW-1:0];
          s_wd  = rd_data;
          s_adv = 1'b1;
        end
      end
      sset_pkg::REQ_LOOKUP: begin
        if (at_end || key_gt) begin
          s_done     = 1'b1;
          res_status = sset_pkg::STAT_ABSENT;
        end else if (key_eq) begin
          s_done    = 1'b1;
          res_found = 1'b1;
          res_pos   = idx_r[AW-1:0];
        end else begin
          s_adv = 1'b1;
        end
      end
      default: begin
        s_done = 1'b1;
        s_cnt  = '0;
      end
    endcase
  end

  // a step commits unless it is the last one and the result slot is taken
  assign commit = (state_r == sset_pkg::FSM_SCAN) && (!s_done || finish_go);

  // next state, memory ports
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    carry_nxt  = carry_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    placed_nxt = placed_r;
    wr_en      = 1'b0;
    wr_addr    = s_wa;
    wr_data    = s_wd;
    rd_addr    = idx_r[AW-1:0];
    case (state_r)
      sset_pkg::FSM_IDLE: begin
        if (in_req.valid) begin
          op_nxt     = sset_pkg::req_type_t'(in_req.req_type);
          key_nxt    = in_req.key;
          idx_nxt    = '0;
          pos_nxt    = '0;
          placed_nxt = 1'b0;
          rd_addr    = '0;
          state_nxt  = sset_pkg::FSM_SCAN;
        end
      end
      sset_pkg::FSM_SCAN: begin
        if (commit) begin
          wr_en      = s_we;
          cnt_nxt    = s_cnt;
          carry_nxt  = s_carry;
          pos_nxt    = s_pos;
          placed_nxt = s_placed;
          if (s_adv) begin
            idx_nxt = idx_inc;
            rd_addr = idx_inc[AW-1:0];
          end
          if (s_done) begin
            state_nxt = sset_pkg::FSM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sset_pkg::FSM_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sset_pkg::FSM_IDLE;
      cnt_r    <= '0;
      idx_r    <= '0;
      placed_r <= 1'b0;
      op_r     <= sset_pkg::REQ_LOOKUP;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      placed_r <= placed_nxt;
      op_r     <= op_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    carry_r <= carry_nxt;
    pos_r   <= pos_nxt;
  end

  // result fields trimmed to their port widths
  assign pos_ext = 64'(res_pos);
  assign cnt_ext = 64'(s_cnt);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (commit && s_done) begin
      out_vld_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && s_done) begin
      out_status_r <= res_status;
      out_found_r  <= res_found;
      out_pos_r    <= pos_ext[sset_pkg::POS_W-1:0];
      out_cnt_r    <= cnt_ext[sset_pkg::COUNT_W-1:0];
    end
  end

  assign out_rsp.valid    = out_vld_r;
  assign out_rsp.status   = out_status_r;
  assign out_rsp.found    = out_found_r;
  assign out_rsp.position = out_pos_r;
  assign out_rsp.count    = out_cnt_r;

  // the count never runs past the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("set count exceeds capacity");

  // an accepted request starts its walk at the lowest entry
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == sset_pkg::FSM_SCAN) && (idx_r == '0))
    else $error("walk did not start at entry zero");

  // the key store is written only during a walk
  a_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == sset_pkg::FSM_SCAN))
    else $error("key store written outside a walk");

  // the count moves by one at a time or drops to zero
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cnt_r) |-> (cnt_r == $past(cnt_r) + CW'(1)) ||
                        (cnt_r == $past(cnt_r) - CW'(1)) || (cnt_r == '0))
    else $error("set count changed by more than one");

endmodule
